// ===== hdl/wlbs_pkg.sv =====
package wlbs_pkg;

    localparam int unsigned NUM_BLOCKS = 1024;

    localparam int unsigned IDX_W   = 10;
    localparam int unsigned ERASE_W = 32;
    localparam int unsigned PAGES_W = 9;
    localparam int unsigned HOST_W  = 64;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CIDX_W  = 2;

    // range check width: wide enough for the largest block count
    localparam int unsigned RANGE_W = 17;

    localparam logic [IDX_W-1:0] POS_MAX = {IDX_W{1'b1}};

    typedef enum logic [1:0] {
        OP_FREE  = 2'd0,
        OP_BLOCK = 2'd1,
        OP_CHECK = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_COLD  = 2'd1,
        KIND_CHECK = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_DYNAMIC = 2'd1,
        MODE_STATIC  = 2'd2
    } mode_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_LEVEL_MODE       = 2'd0,
        REG_CHECK_INTERVAL   = 2'd1,
        REG_SPREAD_THRESHOLD = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [IDX_W-1:0]   block_index;
        logic [ERASE_W-1:0] wear_count;
        logic [PAGES_W-1:0] live_pages;
        logic               is_open;
        logic               last_entry;
        logic [HOST_W-1:0]  host_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [IDX_W-1:0] free_position;
        logic [IDX_W-1:0] cold_block;
        logic             cold_found;
        logic             migrate;
    } out_item_t;

    typedef struct packed {
        logic [1:0]         level_mode;
        logic [ERASE_W-1:0] check_interval;
        logic [ERASE_W-1:0] spread_threshold;
    } cfg_t;

endpackage

// ===== hdl/wlbs_core.sv =====
module wlbs_core (
    input  logic               clk,
    input  logic               rst_n,
    input  wlbs_pkg::cfg_t     cfg,
    input  logic               fire,
    input  wlbs_pkg::in_item_t item,
    output logic               res_valid,
    output wlbs_pkg::out_item_t res
);
    import wlbs_pkg::*;

    logic [IDX_W-1:0]   free_counter_reg, free_counter_next;
    logic [IDX_W-1:0]   free_best_pos_reg, free_best_pos_next;
    logic [ERASE_W-1:0] free_best_erases_reg, free_best_erases_next;
    logic [IDX_W-1:0]   cold_best_index_reg, cold_best_index_next;
    logic [ERASE_W-1:0] cold_best_erases_reg, cold_best_erases_next;
    logic               cold_seen_reg, cold_seen_next;
    logic [ERASE_W-1:0] scan_min_reg, scan_min_next;
    logic [ERASE_W-1:0] scan_max_reg, scan_max_next;
    logic [ERASE_W-1:0] latched_spread_reg, latched_spread_next;
    logic [HOST_W-1:0]  last_check_reg, last_check_next;

    // free list
    logic               free_take;
    logic [IDX_W-1:0]   free_pos_upd;
    logic [ERASE_W-1:0] free_erases_upd;

    // block scan
    logic               in_range;
    logic               cold_cand;
    logic               cold_better;
    logic [ERASE_W-1:0] min_upd, max_upd;
    logic [IDX_W-1:0]   cold_idx_upd;
    logic [ERASE_W-1:0] cold_erases_upd;
    logic               cold_seen_upd;

    // migration check
    logic [HOST_W-1:0]  host_delta;
    logic               check_due;

    always_comb
    begin
        free_take       = (free_counter_reg == '0) || (item.wear_count < free_best_erases_reg);
        free_pos_upd    = free_take ? free_counter_reg : free_best_pos_reg;
        free_erases_upd = free_take ? item.wear_count : free_best_erases_reg;

        in_range = {{(RANGE_W-IDX_W){1'b0}}, item.block_index} < RANGE_W'(NUM_BLOCKS);
        min_upd  = (in_range && item.wear_count < scan_min_reg) ? item.wear_count
                                                                  : scan_min_reg;
        max_upd  = (in_range && item.wear_count > scan_max_reg) ? item.wear_count
                                                                  : scan_max_reg;
        cold_cand   = in_range && (item.live_pages != '0) && !item.is_open;
        cold_better = !cold_seen_reg || (item.wear_count < cold_best_erases_reg) ||
                      ((item.wear_count == cold_best_erases_reg) &&
                       (item.block_index < cold_best_index_reg));
        cold_idx_upd    = (cold_cand && cold_better) ? item.block_index : cold_best_index_reg;
        cold_erases_upd = (cold_cand && cold_better) ? item.wear_count
                                                     : cold_best_erases_reg;
        cold_seen_upd   = cold_seen_reg || cold_cand;

        host_delta = item.host_count - last_check_reg;
        check_due  = (cfg.level_mode == MODE_STATIC) && (cfg.check_interval != '0) &&
                     (host_delta >= {{(HOST_W-ERASE_W){1'b0}}, cfg.check_interval});
    end

    always_comb
    begin
        free_counter_next     = free_counter_reg;
        free_best_pos_next    = free_best_pos_reg;
        free_best_erases_next = free_best_erases_reg;
        cold_best_index_next  = cold_best_index_reg;
        cold_best_erases_next = cold_best_erases_reg;
        cold_seen_next        = cold_seen_reg;
        scan_min_next         = scan_min_reg;
        scan_max_next         = scan_max_reg;
        latched_spread_next   = latched_spread_reg;
        last_check_next       = last_check_reg;
        res_valid             = 1'b0;
        res                   = '0;

        if (fire)
        begin
            unique case (item.opcode)
                OP_FREE:
                begin
                    if (item.last_entry)
                    begin
                        res_valid             = 1'b1;
                        res.result_kind       = KIND_FREE;
                        res.free_position     = (cfg.level_mode == MODE_NONE) ? '0
                                                                              : free_pos_upd;
                        free_counter_next     = '0;
                        free_best_pos_next    = '0;
                        free_best_erases_next = '0;
                    end
                    else
                    begin
                        free_best_pos_next    = free_pos_upd;
                        free_best_erases_next = free_erases_upd;
                        // saturate so an overlong list keeps competing at the top slot
                        free_counter_next     = (free_counter_reg == POS_MAX) ? free_counter_reg
                                                : free_counter_reg + 1'b1;
                    end
                end
                OP_BLOCK:
                begin
                    if (item.last_entry)
                    begin
                        res_valid             = 1'b1;
                        res.result_kind       = KIND_COLD;
                        res.cold_block        = cold_seen_upd ? cold_idx_upd : '0;
                        res.cold_found        = cold_seen_upd;
                        latched_spread_next   = (max_upd >= min_upd) ? max_upd - min_upd : '0;
                        cold_best_index_next  = '0;
                        cold_best_erases_next = '0;
                        cold_seen_next        = 1'b0;
                        scan_min_next         = '1;
                        scan_max_next         = '0;
                    end
                    else
                    begin
                        cold_best_index_next  = cold_idx_upd;
                        cold_best_erases_next = cold_erases_upd;
                        cold_seen_next        = cold_seen_upd;
                        scan_min_next         = min_upd;
                        scan_max_next         = max_upd;
                    end
                end
                OP_CHECK:
                begin
                    res_valid       = 1'b1;
                    res.result_kind = KIND_CHECK;
                    if (check_due)
                    begin
                        last_check_next = item.host_count;
                        res.migrate     = latched_spread_reg > cfg.spread_threshold;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_counter_reg     <= '0;
            free_best_pos_reg    <= '0;
            free_best_erases_reg <= '0;
            cold_best_index_reg  <= '0;
            cold_best_erases_reg <= '0;
            cold_seen_reg        <= 1'b0;
            scan_min_reg         <= '1;
            scan_max_reg         <= '0;
            latched_spread_reg   <= '0;
            last_check_reg       <= '0;
        end
        else
        begin
            free_counter_reg     <= free_counter_next;
            free_best_pos_reg    <= free_best_pos_next;
            free_best_erases_reg <= free_best_erases_next;
            cold_best_index_reg  <= cold_best_index_next;
            cold_best_erases_reg <= cold_best_erases_next;
            cold_seen_reg        <= cold_seen_next;
            scan_min_reg         <= scan_min_next;
            scan_max_reg         <= scan_max_next;
            latched_spread_reg   <= latched_spread_next;
            last_check_reg       <= last_check_next;
        end
    end

    a_free_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.opcode == OP_FREE) && item.last_entry |=> free_counter_reg == '0)
        else $error("free list did not restart after its last entry");

    a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.opcode == OP_BLOCK) && item.last_entry
        |=> (scan_min_reg == '1) && (scan_max_reg == '0) && !cold_seen_reg)
        else $error("scan accumulators not cleared after the last record");

    a_cold_none: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.cold_found |-> res.cold_block == '0)
        else $error("cold block reported without a candidate");

endmodule

// ===== hdl/wear_leveling_block_selector_top.sv =====
// wear-leveling policy engine: takes free-list entries, block records and
// migration checks on one valid/stall input channel and returns at most one
// result beat per item. the last free entry yields the list position of the
// least-worn free block (position zero when the level mode is none), the last
// block record yields the least-worn non-open block holding live data (and
// latches the erase-count spread of the scan), and every migration check
// yields a migrate decision. one item is taken every clock while the result
// side keeps draining; a beat goes through an input register and a result
// register, so a result beat is presented once its item has left the input
// register. the only stall comes from a held result beat, which blocks the
// input stage and through it the input. the rate is set by the running
// minima's compare-and-update, done once per item between the two registers.
// configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while no item is in flight, which the block does not enforce.
module wear_leveling_block_selector_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  wlbs_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output wlbs_pkg::out_item_t         out_data,
    input  logic                        cfg_we,
    input  logic [wlbs_pkg::CIDX_W-1:0] cfg_index,
    input  logic [wlbs_pkg::CFG_W-1:0]  cfg_data
);
    import wlbs_pkg::*;

    // configuration registers
    cfg_t      cfg_reg, cfg_next;

    // input stage
    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_data_reg;

    // result stage
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    logic      accept;
    logic      fire;
    logic      res_valid;
    out_item_t res;

    // the input stage moves on whenever the result slot is empty or drains
    assign fire     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEVEL_MODE:       cfg_next.level_mode       = cfg_data[1:0];
                REG_CHECK_INTERVAL:   cfg_next.check_interval   = cfg_data;
                REG_SPREAD_THRESHOLD: cfg_next.spread_threshold = cfg_data;
                default:              cfg_next = cfg_reg;   // no register there
            endcase
        end
    end

    always_comb
    begin
        priority if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        // items without a result still pass, leaving the slot empty
        priority if (fire)
            out_valid_next = res_valid;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    wlbs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (fire),
        .item      (s1_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= in_data;
        end
        if (fire && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !fire)
        else $error("pending result beat overwritten");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.result_kind == KIND_FREE) ||
                      (out_data.result_kind == KIND_COLD) ||
                      (out_data.result_kind == KIND_CHECK))
        else $error("result beat with unknown kind");

endmodule
